>>> rtl/small_window_median_select_defines.svh
// Assertion macros for the small window median select block.
// Included by the top level; expects clk and arst_n in scope.
`ifndef SMALL_WINDOW_MEDIAN_SELECT_DEFINES_SVH
`define SMALL_WINDOW_MEDIAN_SELECT_DEFINES_SVH

// same-cycle implication
`define SMWS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMWS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/smws_pkg.sv
// Package for the small window median select block.
// Shared constants and the cell control struct; no dependencies.
`timescale 1ns / 1ps

package smws_pkg;

	localparam int MAX_SAMPLES_DEF  = 7;
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int MIN_SAMPLES      = 3;
	localparam int MODE_W           = 3;
	localparam int FIELD_W          = 32;
	localparam int SEL_W            = 3;

	typedef struct packed {
		logic             vld;
		logic [SEL_W-1:0] sel;
	} smws_ctl_t;

endpackage

>>> rtl/smws_cell.sv
// One odd-even transposition cell: compare-exchange on its lane pairs, then register.
// Depends on smws_pkg for the control struct.
`timescale 1ns / 1ps

module smws_cell import smws_pkg::*; #(
	parameter int N     = MAX_SAMPLES_DEF,
	parameter int W     = SAMPLE_WIDTH_DEF,
	parameter bit PHASE = 1'b0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  smws_ctl_t    ctl_in,
	input  logic [W-1:0] data_in  [N],
	output smws_ctl_t    ctl_out,
	output logic [W-1:0] data_out [N]
);

	logic [W-1:0] data_nxt [N];
	logic [W-1:0] data_q   [N];
	smws_ctl_t    ctl_q;

	always_comb begin
		data_nxt = data_in;
		for (int i = int'(PHASE); i + 1 < N; i += 2) begin
			if ($signed(data_in[i]) > $signed(data_in[i+1])) begin
				data_nxt[i]   = data_in[i+1];
				data_nxt[i+1] = data_in[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign ctl_out  = ctl_q;
	assign data_out = data_q;

endmodule

>>> rtl/small_window_median_select.sv
// Top level of the small window median select block.
// Depends on smws_pkg, smws_cell and small_window_median_select_defines.svh.
`timescale 1ns / 1ps
`include "small_window_median_select_defines.svh"

// Takes one window per clock and returns the sample at ascending sorted position
// floor(count/2): the median for odd counts, the upper middle value for 4 and 6.
// A mode below 3 counts as 3, one above MAX_SAMPLES as MAX_SAMPLES. The sort is a
// row of MAX_SAMPLES odd-even transposition cells plus one output register, so
// done pulses for one cycle once a transfer has passed every cell and the output
// register; results leave in order at up to one per cycle. The receiver cannot
// stall; busy is high only in the first cycle after reset and otherwise stays low.

module small_window_median_select import smws_pkg::*; #(
	parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic        [MODE_W-1:0]   mode,
	input  logic signed [FIELD_W-1:0]  sample_0,
	input  logic signed [FIELD_W-1:0]  sample_1,
	input  logic signed [FIELD_W-1:0]  sample_2,
	input  logic signed [FIELD_W-1:0]  sample_3,
	input  logic signed [FIELD_W-1:0]  sample_4,
	input  logic signed [FIELD_W-1:0]  sample_5,
	input  logic signed [FIELD_W-1:0]  sample_6,
	output logic                       done,
	output logic signed [FIELD_W-1:0]  median_value
);

	localparam int N     = MAX_SAMPLES;
	localparam int W     = SAMPLE_WIDTH;
	localparam int IDX_W = $clog2(N);
	localparam logic [W-1:0] PAD = {1'b0, {(W-1){1'b1}}};

	logic [FIELD_W-1:0] samp [7];
	logic [MODE_W-1:0]  cnt;
	logic [W-1:0]       chain_data [N+1][N];
	smws_ctl_t          chain_ctl  [N+1];
	logic               busy_q;
	logic               done_q;
	logic [FIELD_W-1:0] median_q;

	assign samp[0] = sample_0;
	assign samp[1] = sample_1;
	assign samp[2] = sample_2;
	assign samp[3] = sample_3;
	assign samp[4] = sample_4;
	assign samp[5] = sample_5;
	assign samp[6] = sample_6;

	always_comb begin
		if (mode < MODE_W'(MIN_SAMPLES)) begin
			cnt = MODE_W'(MIN_SAMPLES);
		end else if (mode > MODE_W'(N)) begin
			cnt = MODE_W'(N);
		end else begin
			cnt = mode;
		end
	end

	// lanes past the count get the largest key so they sort to the top
	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (MODE_W'(i) < cnt) begin
				chain_data[0][i] = W'(samp[i]);
			end else begin
				chain_data[0][i] = PAD;
			end
		end
		chain_ctl[0].vld = start & ~busy;
		chain_ctl[0].sel = SEL_W'(cnt >> 1);
	end

	for (genvar k = 0; k < N; k++) begin : g_cell
		smws_cell #(
			.N     (N),
			.W     (W),
			.PHASE (1'(k % 2))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (chain_ctl[k]),
			.data_in  (chain_data[k]),
			.ctl_out  (chain_ctl[k+1]),
			.data_out (chain_data[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			done_q <= chain_ctl[N].vld;
		end
	end

	always_ff @(posedge clk) begin
		median_q <= FIELD_W'(chain_data[N][chain_ctl[N].sel[IDX_W-1:0]]);
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign median_value = $signed(median_q);

	`SMWS_ASSERT_IMP(a_latency, start && !busy, ##(N+1) done, "result strobe missing")
	`SMWS_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, N+1), "result without transfer")
	`SMWS_ASSERT_IMP(a_sel_range, chain_ctl[1].vld,
		(chain_ctl[1].sel >= SEL_W'(MIN_SAMPLES / 2)) && (chain_ctl[1].sel <= SEL_W'(N / 2)),
		"median index out of range")
	`SMWS_ASSERT_NXT(a_busy_clear, !busy, !busy, "busy raised after reset")

endmodule
